// File: rtl/b64_pkg.sv
// Shared types, constants and character mapping functions for the Base64 codec.
// No dependencies; every other file of the block but b64_if.sv imports this package.
package b64_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_RES     = 4;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_CHAR  = 2'd1;
    localparam logic [1:0] ERR_LONE_CHAR = 2'd2;

    typedef enum logic
    {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef struct packed
    {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [1:0]              last_idx;
        logic                    eom;
        logic                    nodata;
        logic [1:0]              err;
    } cmd_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed
    {
        logic       pad;
        logic       bad;
        logic [5:0] value;
    } sextet_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26)
        begin
            r = 8'h41 + {2'b00, v};
        end
        else if (v < 6'd52)
        begin
            r = 8'h61 + {2'b00, v - 6'd26};
        end
        else if (v < 6'd62)
        begin
            r = 8'h30 + {2'b00, v - 6'd52};
        end
        else if (v == 6'd62)
        begin
            r = 8'h2B;
        end
        else
        begin
            r = 8'h2F;
        end
        return r;
    endfunction

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s = '0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            s.value = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            s.value = 6'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            s.value = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B)
        begin
            s.value = 6'd62;
        end
        else if (c == 8'h2F)
        begin
            s.value = 6'd63;
        end
        else if (c == PAD_CHAR)
        begin
            s.pad = 1'b1;
        end
        else
        begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

endpackage

// File: rtl/b64_if.sv
// Handshake channel interfaces of the Base64 codec: requests, results, configuration.
// No dependencies.
interface b64_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_message;

    modport source (output valid, output in_byte, output end_of_message, input ready);
    modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface b64_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_end;
    logic       no_data;
    logic [1:0] error_code;

    modport source (output valid, output out_byte, output run_last, output message_end,
                    output no_data, output error_code, input ready);
    modport sink   (input valid, input out_byte, input run_last, input message_end,
                    input no_data, input error_code, output ready);
endinterface

interface b64_cfg_if;
    logic valid;
    logic ready;
    logic direction_mode;

    modport source (output valid, output direction_mode, input ready);
    modport sink   (input valid, input direction_mode, output ready);
endinterface

// File: rtl/base64_codec.sv
// Top level of the streaming Base64 codec: front end, command queue and result serialiser.
// Depends on b64_pkg, b64_if.sv, b64_front, b64_queue and b64_back.
//
// A request is taken in every cycle while the four-entry command queue has room; its
// results go through the queue and leave one per cycle from the serialiser while the result
// channel is ready. Encoding turns three bytes into four characters, so a steady encode
// stream is held back by the one-result-per-cycle serialiser; decoding makes three bytes per
// four characters and runs at one request per cycle while results are taken. Configuration
// writes are always ready and clear the group state; write only while the block is idle.
module base64_codec
(
    input  logic      clk,
    input  logic      rst_n,
    b64_req_if.sink   req,
    b64_rsp_if.source rsp,
    b64_cfg_if.sink   cfg
);
    import b64_pkg::*;

    cmd_t      push_cmd;
    cmd_t      head;
    q_status_t q_status;
    logic      push;
    logic      pop;

    b64_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg      (cfg),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    b64_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    b64_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .rsp      (rsp)
    );

endmodule

// File: rtl/b64_front.sv
// Front end: accepts requests, keeps group state and builds a result command per finished group.
// Depends on b64_pkg and the channel interfaces in b64_if.sv.
module b64_front
(
    input  logic             clk,
    input  logic             rst_n,
    b64_req_if.sink          req,
    b64_cfg_if.sink          cfg,
    input  b64_pkg::q_status_t q_status,
    output logic             push,
    output b64_pkg::cmd_t    push_cmd
);
    import b64_pkg::*;

    mode_t       mode_reg;
    logic [23:0] bits_reg;
    logic [1:0]  cnt_reg;
    logic        bad_reg;

    logic [23:0] g_bits;
    logic [1:0]  g_cnt;
    logic        g_bad;
    logic [2:0]  n_res;
    logic [MAX_RES-1:0][7:0] res_bytes;
    logic [1:0]  res_err;
    logic        res_nodata;

    logic        item_acc;
    logic        cfg_acc;
    sextet_t     sx;
    logic [23:0] enc_sh;
    logic [1:0]  enc_cnt;
    logic [23:0] dec_sh;
    logic        eom;

    assign req.ready = !q_status.full;
    assign cfg.ready = 1'b1;
    assign item_acc  = req.valid && req.ready;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign eom       = req.end_of_message;

    assign sx      = sextet_of(req.in_byte);
    assign enc_sh  = {bits_reg[15:0], req.in_byte};
    assign enc_cnt = cnt_reg + 2'd1;
    assign dec_sh  = {bits_reg[17:0], sx.value};

    always_comb
    begin
        g_bits     = bits_reg;
        g_cnt      = cnt_reg;
        g_bad      = bad_reg;
        n_res      = 3'd0;
        res_bytes  = '0;
        res_err    = ERR_NONE;
        res_nodata = 1'b0;
        if (mode_reg == MODE_ENCODE)
        begin
            g_bits = enc_sh;
            g_cnt  = enc_cnt;
            if (enc_cnt == 2'd3)
            begin
                res_bytes[0] = enc_char(enc_sh[23:18]);
                res_bytes[1] = enc_char(enc_sh[17:12]);
                res_bytes[2] = enc_char(enc_sh[11:6]);
                res_bytes[3] = enc_char(enc_sh[5:0]);
                n_res  = 3'd4;
                g_bits = '0;
                g_cnt  = 2'd0;
            end
            else if (eom && enc_cnt == 2'd1)
            begin
                res_bytes[0] = enc_char(enc_sh[7:2]);
                res_bytes[1] = enc_char({enc_sh[1:0], 4'b0000});
                res_bytes[2] = PAD_CHAR;
                res_bytes[3] = PAD_CHAR;
                n_res = 3'd4;
            end
            else if (eom && enc_cnt == 2'd2)
            begin
                res_bytes[0] = enc_char(enc_sh[15:10]);
                res_bytes[1] = enc_char(enc_sh[9:4]);
                res_bytes[2] = enc_char({enc_sh[3:0], 2'b00});
                res_bytes[3] = PAD_CHAR;
                n_res = 3'd4;
            end
        end
        else
        begin
            if (sx.bad)
            begin
                g_bad = 1'b1;
            end
            else if (!sx.pad)
            begin
                if (cnt_reg == 2'd3)
                begin
                    res_bytes[0] = dec_sh[23:16];
                    res_bytes[1] = dec_sh[15:8];
                    res_bytes[2] = dec_sh[7:0];
                    n_res  = 3'd3;
                    g_bits = '0;
                    g_cnt  = 2'd0;
                end
                else
                begin
                    g_bits = dec_sh;
                    g_cnt  = cnt_reg + 2'd1;
                end
            end
            if (eom)
            begin
                case (g_cnt)
                    2'd2:
                    begin
                        res_bytes[0] = g_bits[11:4];
                        n_res = 3'd1;
                    end
                    2'd3:
                    begin
                        res_bytes[0] = g_bits[17:10];
                        res_bytes[1] = g_bits[9:2];
                        n_res = 3'd2;
                    end
                    2'd1:
                    begin
                        res_err = ERR_LONE_CHAR;
                    end
                    default:
                    begin
                    end
                endcase
                if (g_bad)
                begin
                    res_err = ERR_BAD_CHAR;
                end
                if (n_res == 3'd0)
                begin
                    res_nodata = 1'b1;
                    n_res      = 3'd1;
                end
            end
        end
    end

    assign push              = item_acc && (n_res != 3'd0);
    assign push_cmd.bytes    = res_bytes;
    assign push_cmd.last_idx = 2'(n_res - 3'd1);
    assign push_cmd.eom      = eom;
    assign push_cmd.nodata   = res_nodata;
    assign push_cmd.err      = eom ? res_err : ERR_NONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENCODE;
            bits_reg <= '0;
            cnt_reg  <= '0;
            bad_reg  <= 1'b0;
        end
        else if (cfg_acc)
        begin
            mode_reg <= mode_t'(cfg.direction_mode);
            bits_reg <= '0;
            cnt_reg  <= '0;
            bad_reg  <= 1'b0;
        end
        else if (item_acc)
        begin
            if (eom)
            begin
                bits_reg <= '0;
                cnt_reg  <= '0;
                bad_reg  <= 1'b0;
            end
            else
            begin
                bits_reg <= g_bits;
                cnt_reg  <= g_cnt;
                bad_reg  <= g_bad;
            end
        end
    end

endmodule

// File: rtl/b64_queue.sv
// Command queue between front end and result serialiser.
// Depends on b64_pkg.
module b64_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b64_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output b64_pkg::cmd_t      head,
    output b64_pkg::q_status_t status
);
    import b64_pkg::*;

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("command pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("command popped from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> count_reg == $past(count_reg) + CNT_W'($past(push))
                                      - CNT_W'($past(pop)))
        else $error("queue occupancy does not follow push and pop");

endmodule

// File: rtl/b64_back.sv
// Result serialiser: walks the head command out, one result per cycle while rsp is ready.
// Depends on b64_pkg and b64_rsp_if in b64_if.sv.
module b64_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  b64_pkg::cmd_t      head,
    input  b64_pkg::q_status_t q_status,
    output logic               pop,
    b64_rsp_if.source          rsp
);
    import b64_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       at_last;
    logic       rsp_acc;

    assign at_last = (idx_reg == head.last_idx);
    assign rsp_acc = rsp.valid && rsp.ready;
    assign pop     = rsp_acc && at_last;

    assign rsp.valid       = !q_status.empty;
    assign rsp.out_byte    = head.bytes[idx_reg];
    assign rsp.run_last    = at_last;
    assign rsp.message_end = at_last && head.eom;
    assign rsp.no_data     = head.nodata;
    assign rsp.error_code  = (at_last && head.eom) ? head.err : ERR_NONE;

    always_comb
    begin
        idx_next = idx_reg;
        if (rsp_acc)
        begin
            idx_next = at_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// File: tb/base64_codec_tb.sv
// Self-checking testbench for base64_codec: directed table, then random messages in both modes.
// Depends on b64_pkg (rtl/b64_pkg.sv), the channel interfaces (rtl/b64_if.sv) and the RTL top.
// An in-bench codec predictor supplies expected characters and bytes but for typed table rows.
module base64_codec_tb;
    import b64_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 250;
    localparam int RANDOM_ITEMS  = 175;
    localparam int PHASE_ITEMS   = 25;

    localparam logic [6:0] SEXTET_PAD = 7'd64;
    localparam logic [6:0] SEXTET_BAD = 7'd65;

    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_end;
        logic       no_data;
        logic [1:0] error_code;
    } codec_out_t;

    typedef struct packed
    {
        mode_t       mode;
        logic [7:0]  chr;
        logic        eom;
        logic        typed;
        logic [2:0]  n_ref;
        logic [31:0] ref_chars;
        logic        ref_nodata;
        logic [1:0]  ref_err;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [25] = '{
        '{MODE_ENCODE, 8'h00, 1'b0, 1'b0, 3'd0, 32'h0,      1'b0, ERR_NONE},
        '{MODE_ENCODE, 8'h00, 1'b0, 1'b0, 3'd0, 32'h0,      1'b0, ERR_NONE},
        '{MODE_ENCODE, 8'h00, 1'b0, 1'b1, 3'd4, "AAAA",     1'b0, ERR_NONE},
        '{MODE_ENCODE, 8'hFF, 1'b0, 1'b0, 3'd0, 32'h0,      1'b0, ERR_NONE},
        '{MODE_ENCODE, 8'hFF, 1'b0, 1'b0, 3'd0, 32'h0,      1'b0, ERR_NONE},
        '{MODE_ENCODE, 8'hFF, 1'b1, 1'b1, 3'd4, "////",     1'b0, ERR_NONE},
        '{MODE_ENCODE, 8'hFF, 1'b1, 1'b1, 3'd4, "/w==",     1'b0, ERR_NONE},
        '{MODE_ENCODE, 8'hFF, 1'b0, 1'b0, 3'd0, 32'h0,      1'b0, ERR_NONE},
        '{MODE_ENCODE, 8'h00, 1'b1, 1'b1, 3'd4, "/wA=",     1'b0, ERR_NONE},
        '{MODE_ENCODE, 8'h4D, 1'b0, 1'b0, 3'd0, 32'h0,      1'b0, ERR_NONE},
        '{MODE_ENCODE, 8'h61, 1'b1, 1'b0, 3'd0, 32'h0,      1'b0, ERR_NONE},
        '{MODE_ENCODE, 8'h80, 1'b0, 1'b0, 3'd0, 32'h0,      1'b0, ERR_NONE},
        '{MODE_DECODE, "T",   1'b0, 1'b0, 3'd0, 32'h0,      1'b0, ERR_NONE},
        '{MODE_DECODE, "W",   1'b0, 1'b0, 3'd0, 32'h0,      1'b0, ERR_NONE},
        '{MODE_DECODE, "F",   1'b0, 1'b0, 3'd0, 32'h0,      1'b0, ERR_NONE},
        '{MODE_DECODE, "u",   1'b1, 1'b1, 3'd3, 32'h4D616E00, 1'b0, ERR_NONE},
        '{MODE_DECODE, "=",   1'b1, 1'b1, 3'd1, 32'h0,      1'b1, ERR_NONE},
        '{MODE_DECODE, "Q",   1'b1, 1'b1, 3'd1, 32'h0,      1'b1, ERR_LONE_CHAR},
        '{MODE_DECODE, 8'hFF, 1'b0, 1'b0, 3'd0, 32'h0,      1'b0, ERR_NONE},
        '{MODE_DECODE, "A",   1'b0, 1'b0, 3'd0, 32'h0,      1'b0, ERR_NONE},
        '{MODE_DECODE, "B",   1'b1, 1'b1, 3'd1, 32'h0,      1'b0, ERR_BAD_CHAR},
        '{MODE_DECODE, 8'h00, 1'b1, 1'b1, 3'd1, 32'h0,      1'b1, ERR_BAD_CHAR},
        '{MODE_DECODE, "/",   1'b0, 1'b0, 3'd0, 32'h0,      1'b0, ERR_NONE},
        '{MODE_DECODE, "/",   1'b0, 1'b0, 3'd0, 32'h0,      1'b0, ERR_NONE},
        '{MODE_DECODE, "/",   1'b1, 1'b1, 3'd2, 32'hFFFF0000, 1'b0, ERR_NONE}
    };

    logic clk = 1'b0;
    logic rst_n;

    b64_req_if req_ch();
    b64_rsp_if rsp_ch();
    b64_cfg_if cfg_ch();

    base64_codec dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    logic [6:0] sextet_lut [256];

    mode_t       codec_mode;
    logic [23:0] grp_bits;
    logic [1:0]  grp_count;
    logic        grp_bad;

    codec_out_t step_out [4];
    int         step_n;
    codec_out_t awaited_out [$];
    logic [7:0] text_buf [$];

    int fail_count  = 0;
    int cycle_count = 0;
    int items_sent  = 0;
    int hold_left   = 0;
    bit long_hold_req = 1'b0;
    bit tx_gaps_on  = 1'b1;
    bit rx_gaps_on  = 1'b1;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [7:0] enc_sextet(input logic [5:0] v);
        return b64_alphabet[int'(v)];
    endfunction

    function automatic void clear_group();
        grp_bits  = '0;
        grp_count = '0;
        grp_bad   = 1'b0;
    endfunction

    function automatic void emit(input logic [7:0] b, input logic nodata);
        step_out[step_n] = '{out_byte: b, run_last: 1'b0, message_end: 1'b0,
                             no_data: nodata, error_code: ERR_NONE};
        step_n++;
    endfunction

    function automatic void predict_codec_step(input logic [7:0] c, input logic eom);
        logic [6:0]  v;
        logic [23:0] t;
        logic [1:0]  err;
        step_n = 0;
        err    = ERR_NONE;
        if (codec_mode == MODE_ENCODE)
        begin
            grp_bits  = {grp_bits[15:0], c};
            grp_count = grp_count + 2'd1;
            if (grp_count == 2'd3)
            begin
                emit(enc_sextet(grp_bits[23:18]), 1'b0);
                emit(enc_sextet(grp_bits[17:12]), 1'b0);
                emit(enc_sextet(grp_bits[11:6]), 1'b0);
                emit(enc_sextet(grp_bits[5:0]), 1'b0);
                grp_count = '0;
                grp_bits  = '0;
            end
            else if (eom && grp_count == 2'd1)
            begin
                t = {grp_bits[7:0], 16'h0};
                emit(enc_sextet(t[23:18]), 1'b0);
                emit(enc_sextet(t[17:12]), 1'b0);
                emit(PAD_CHAR, 1'b0);
                emit(PAD_CHAR, 1'b0);
            end
            else if (eom && grp_count == 2'd2)
            begin
                t = {grp_bits[15:0], 8'h0};
                emit(enc_sextet(t[23:18]), 1'b0);
                emit(enc_sextet(t[17:12]), 1'b0);
                emit(enc_sextet(t[11:6]), 1'b0);
                emit(PAD_CHAR, 1'b0);
            end
        end
        else
        begin
            v = sextet_lut[c];
            if (v == SEXTET_BAD)
            begin
                grp_bad = 1'b1;
            end
            else if (v != SEXTET_PAD)
            begin
                grp_bits = {grp_bits[17:0], v[5:0]};
                if (grp_count == 2'd3)
                begin
                    emit(grp_bits[23:16], 1'b0);
                    emit(grp_bits[15:8], 1'b0);
                    emit(grp_bits[7:0], 1'b0);
                    grp_count = '0;
                    grp_bits  = '0;
                end
                else
                begin
                    grp_count = grp_count + 2'd1;
                end
            end
            if (eom)
            begin
                if (grp_count == 2'd2)
                begin
                    emit(grp_bits[11:4], 1'b0);
                end
                else if (grp_count == 2'd3)
                begin
                    emit(grp_bits[17:10], 1'b0);
                    emit(grp_bits[9:2], 1'b0);
                end
                else if (grp_count == 2'd1)
                begin
                    err = ERR_LONE_CHAR;
                end
                if (grp_bad)
                begin
                    err = ERR_BAD_CHAR;
                end
                if (step_n == 0)
                begin
                    emit(8'h00, 1'b1);
                end
            end
        end
        if (step_n > 0)
        begin
            step_out[step_n-1].run_last = 1'b1;
            if (eom)
            begin
                step_out[step_n-1].message_end = 1'b1;
                step_out[step_n-1].error_code  = err;
            end
        end
        if (eom)
        begin
            clear_group();
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    function automatic void push_predicted();
        for (int k = 0; k < step_n; k++)
        begin
            awaited_out.push_back(step_out[k]);
        end
    endfunction

    function automatic void push_typed(input dir_row_t row);
        codec_out_t r;
        for (int k = 0; k < row.n_ref; k++)
        begin
            r.out_byte    = row.ref_chars[31 - 8*k -: 8];
            r.run_last    = (k == row.n_ref - 1);
            r.message_end = row.eom && (k == row.n_ref - 1);
            r.no_data     = row.ref_nodata;
            r.error_code  = (k == row.n_ref - 1) ? row.ref_err : ERR_NONE;
            awaited_out.push_back(r);
        end
    endfunction

    function automatic void build_text(input int nbytes, input bit pad);
        logic [23:0] g;
        int r;
        text_buf.delete();
        for (int k = 0; k < nbytes; k += 3)
        begin
            r = nbytes - k;
            g = {8'($urandom_range(0, 255)),
                 (r > 1) ? 8'($urandom_range(0, 255)) : 8'h00,
                 (r > 2) ? 8'($urandom_range(0, 255)) : 8'h00};
            text_buf.push_back(enc_sextet(g[23:18]));
            text_buf.push_back(enc_sextet(g[17:12]));
            if (r > 1)
            begin
                text_buf.push_back(enc_sextet(g[11:6]));
            end
            else if (pad)
            begin
                text_buf.push_back(PAD_CHAR);
            end
            if (r > 2)
            begin
                text_buf.push_back(enc_sextet(g[5:0]));
            end
            else if (pad)
            begin
                text_buf.push_back(PAD_CHAR);
            end
        end
    endfunction

    task automatic send_raw(input logic [7:0] b, input logic eom);
        req_ch.valid          <= 1'b1;
        req_ch.in_byte        <= b;
        req_ch.end_of_message <= eom;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        predict_codec_step(b, eom);
        items_sent++;
    endtask

    task automatic idle_tx();
        int gap;
        if (tx_gaps_on && $urandom_range(0, 2) == 0)
        begin
            gap = pick_gap();
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_item(input logic [7:0] b, input logic eom);
        send_raw(b, eom);
        push_predicted();
        idle_tx();
    endtask

    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        while (awaited_out.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_mode(input mode_t m);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.direction_mode <= m;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        codec_mode = m;
        clear_group();
    endtask

    task automatic send_text();
        for (int k = 0; k < text_buf.size(); k++)
        begin
            send_item(text_buf[k], k == text_buf.size() - 1);
        end
    endtask

    task automatic send_enc_message();
        int len;
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++)
        begin
            send_item(8'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    task automatic send_dec_message();
        int kind;
        int len;
        kind = $urandom_range(0, 9);
        text_buf.delete();
        if (kind == 9)
        begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                text_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
        else if (kind == 8)
        begin
            len = 4 * $urandom_range(0, 2) + 1;
            for (int k = 0; k < len; k++)
            begin
                text_buf.push_back(enc_sextet(6'($urandom_range(0, 63))));
            end
        end
        else
        begin
            build_text($urandom_range(1, 9), 1'($urandom_range(0, 1)));
            if (kind == 7)
            begin
                text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
            end
            else if (kind == 6)
            begin
                text_buf.insert($urandom_range(0, text_buf.size() - 1), PAD_CHAR);
            end
        end
        send_text();
    endtask

    always @(posedge clk)
    begin : result_check
        codec_out_t exp_o;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_out.size() == 0)
            begin
                $error("unexpected result: out_byte %0h", rsp_ch.out_byte);
                fail_count++;
            end
            else
            begin
                exp_o = awaited_out.pop_front();
                check_field("out_byte", exp_o.out_byte, rsp_ch.out_byte);
                check_field("run_last", 8'(exp_o.run_last), 8'(rsp_ch.run_last));
                check_field("message_end", 8'(exp_o.message_end), 8'(rsp_ch.message_end));
                check_field("no_data", 8'(exp_o.no_data), 8'(rsp_ch.no_data));
                check_field("error_code", 8'(exp_o.error_code), 8'(rsp_ch.error_code));
            end
        end
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (rx_gaps_on && $urandom_range(0, 4) == 0)
            begin
                hold_left     = pick_gap() - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int    phase;
        int    phase_start;
        int    random_start;
        mode_t phase_mode;
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.in_byte        = 8'h00;
        req_ch.end_of_message = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.direction_mode = MODE_ENCODE;
        for (int i = 0; i < 256; i++)
        begin
            sextet_lut[i] = SEXTET_BAD;
        end
        for (int i = 0; i < 64; i++)
        begin
            sextet_lut[b64_alphabet[i]] = 7'(i);
        end
        sextet_lut[PAD_CHAR] = SEXTET_PAD;
        codec_mode = MODE_ENCODE;
        clear_group();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        write_mode(MODE_ENCODE);

        for (int i = 0; i < $size(DIR_ROWS); i++)
        begin
            if (DIR_ROWS[i].mode != codec_mode)
            begin
                write_mode(DIR_ROWS[i].mode);
            end
            send_raw(DIR_ROWS[i].chr, DIR_ROWS[i].eom);
            if (DIR_ROWS[i].typed)
            begin
                push_typed(DIR_ROWS[i]);
            end
            else
            begin
                push_predicted();
            end
            idle_tx();
        end

        random_start = items_sent;
        phase        = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            phase_mode = ($urandom_range(0, 3) == 0) ? codec_mode
                                                     : mode_t'(codec_mode == MODE_ENCODE);
            if (phase == 1)
            begin
                phase_mode = MODE_ENCODE;
            end
            write_mode(phase_mode);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            if (phase == 1)
            begin
                tx_gaps_on    = 1'b0;
                long_hold_req = 1'b1;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if (codec_mode == MODE_ENCODE)
                begin
                    send_enc_message();
                end
                else
                begin
                    send_dec_message();
                end
                if (phase == 2 && items_sent - phase_start < 12)
                begin
                    wait_drain();
                end
            end
            // leave a partial group behind for the next register write to clear
            if ($urandom_range(0, 2) == 0)
            begin
                repeat ($urandom_range(1, 2)) send_item(8'($urandom_range(0, 255)), 1'b0);
            end
            phase++;
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/b64_pkg.sv
rtl/b64_if.sv
rtl/b64_front.sv
rtl/b64_queue.sv
rtl/b64_back.sv
rtl/base64_codec.sv
tb/base64_codec_tb.sv
